>>> sv/shss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shss_pkg;

    localparam int POSITION_BITS = 16;
    localparam int TIMER_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int TRAVEL_BITS   = 15;

    // command opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_HOME = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_DELAY      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWITCH_LOCKOUT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOME_CORRECTION = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOMING_TRAVEL   = 3'd3;

    localparam logic [TIMER_BITS-1:0]  RST_STEP_DELAY     = 16'd2;
    localparam logic [TIMER_BITS-1:0]  RST_SWITCH_LOCKOUT = 16'd100;
    localparam logic [TRAVEL_BITS-1:0] RST_HOMING_TRAVEL  = 15'd30000;

    typedef struct packed {
        logic [1:0]                       opcode;
        logic signed [POSITION_BITS-1:0]  target_offset;
        logic                             left_switch;
        logic                             right_switch;
    } t_cmd;

    typedef struct packed {
        logic                             step_out;
        logic                             direction;
        logic                             driver_enable_n;
        logic signed [POSITION_BITS-1:0]  position;
        logic signed [POSITION_BITS-1:0]  steps_remaining;
        logic signed [POSITION_BITS-1:0]  home_position;
        logic                             homing_active;
        logic                             left_hit;
        logic                             right_hit;
    } t_status;

endpackage

`default_nettype wire

>>> sv/stepper_homing_step_sequencer.sv
// Step/direction stepper sequencer with limit switches and homing. Each command transfer
// (tick, move or start-homing) updates the motion state and loads one status result into
// the output register, so one command is taken every cycle while input ready is high, and
// the status appears in the cycle after its command. The output register frees up in the
// same cycle that its result is taken, so input ready is low only while a result is held
// by the consumer. Configuration writes land immediately and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module stepper_homing_step_sequencer
    import shss_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire t_cmd                     i_cmd,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output t_status                       o_status
);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    logic [TIMER_BITS-1:0]    r_step_delay;
    logic [TIMER_BITS-1:0]    r_switch_lockout;
    logic [TRAVEL_BITS-1:0]   r_home_correction;
    logic [TRAVEL_BITS-1:0]   r_homing_travel;

    logic [POSITION_BITS-1:0] r_steps_left,  n_steps_left;
    logic [POSITION_BITS-1:0] r_position,    n_position;
    logic [POSITION_BITS-1:0] r_home,        n_home;
    logic                     r_step_level,  n_step_level;
    logic                     r_dir,         n_dir;
    logic                     r_enabled,     n_enabled;
    logic                     r_homing,      n_homing;
    logic [TIMER_BITS-1:0]    r_step_wait,   n_step_wait;
    logic [TIMER_BITS-1:0]    r_lock_wait,   n_lock_wait;
    logic                     r_out_valid;
    t_status                  r_status,      n_status;

    logic                     accept;
    logic                     lhit, rhit;
    logic [POSITION_BITS-1:0] span;
    logic [POSITION_BITS-1:0] half_span;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    always_comb begin
        n_steps_left = r_steps_left;
        n_position   = r_position;
        n_home       = r_home;
        n_step_level = r_step_level;
        n_dir        = r_dir;
        n_enabled    = r_enabled;
        n_homing     = r_homing;
        n_step_wait  = r_step_wait;
        n_lock_wait  = r_lock_wait;
        lhit         = 1'b0;
        rhit         = 1'b0;
        span         = '0;
        half_span    = '0;

        unique case (i_cmd.opcode)
            OP_MOVE: begin
                n_steps_left = r_home + POSITION_BITS'(i_cmd.target_offset) - r_position;
            end
            OP_HOME: begin
                n_homing     = 1'b1;
                n_steps_left = '0 - POSITION_BITS'(r_homing_travel);
            end
            OP_TICK: begin
                n_step_wait = (r_step_wait == TIMER_MAX) ? TIMER_MAX : r_step_wait + 1'b1;
                n_lock_wait = (r_lock_wait == TIMER_MAX) ? TIMER_MAX : r_lock_wait + 1'b1;
                if (r_steps_left != '0 && n_step_wait > r_step_delay) begin
                    n_enabled = 1'b1;
                    // nonzero with sign clear means moving positive
                    n_dir = !r_steps_left[POSITION_BITS-1];
                    if (!r_step_level) begin
                        if (n_dir) begin
                            n_steps_left = r_steps_left - 1'b1;
                            n_position   = r_position + 1'b1;
                        end else begin
                            n_steps_left = r_steps_left + 1'b1;
                            n_position   = r_position - 1'b1;
                        end
                    end
                    n_step_level = !r_step_level;
                    n_step_wait  = '0;
                    // an accepted left hit zeroes the lockout, which masks the right switch
                    if (i_cmd.left_switch && n_lock_wait > r_switch_lockout) begin
                        lhit        = 1'b1;
                        n_lock_wait = '0;
                        if (r_homing) begin
                            n_position   = '0;
                            n_steps_left = POSITION_BITS'(r_homing_travel);
                        end else begin
                            n_steps_left = r_home - n_position;
                        end
                    end else if (i_cmd.right_switch && n_lock_wait > r_switch_lockout) begin
                        rhit        = 1'b1;
                        n_lock_wait = '0;
                        if (r_homing) begin
                            span = n_position - POSITION_BITS'(r_home_correction);
                            // signed halving, truncated toward zero
                            half_span = POSITION_BITS'(($signed(span)
                                + $signed({{(POSITION_BITS-1){1'b0}},
                                           span[POSITION_BITS-1]})) >>> 1);
                            n_home       = half_span;
                            n_steps_left = '0 - half_span;
                            n_homing     = 1'b0;
                        end else begin
                            n_steps_left = r_home - n_position;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        n_status.step_out        = n_step_level;
        n_status.direction       = n_dir;
        n_status.driver_enable_n = !n_enabled;
        n_status.position        = n_position;
        n_status.steps_remaining = n_steps_left;
        n_status.home_position   = n_home;
        n_status.homing_active   = n_homing;
        n_status.left_hit        = lhit;
        n_status.right_hit       = rhit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay      <= RST_STEP_DELAY;
            r_switch_lockout  <= RST_SWITCH_LOCKOUT;
            r_home_correction <= '0;
            r_homing_travel   <= RST_HOMING_TRAVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STEP_DELAY:      r_step_delay      <= i_cfg_data;
                REG_SWITCH_LOCKOUT:  r_switch_lockout  <= i_cfg_data;
                REG_HOME_CORRECTION: r_home_correction <= i_cfg_data[TRAVEL_BITS-1:0];
                REG_HOMING_TRAVEL:   r_homing_travel   <= i_cfg_data[TRAVEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_left <= '0;
            r_position   <= '0;
            r_home       <= '0;
            r_step_level <= 1'b0;
            r_dir        <= 1'b0;
            r_enabled    <= 1'b0;
            r_homing     <= 1'b0;
            r_step_wait  <= TIMER_MAX;
            r_lock_wait  <= TIMER_MAX;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_steps_left <= n_steps_left;
                r_position   <= n_position;
                r_home       <= n_home;
                r_step_level <= n_step_level;
                r_dir        <= n_dir;
                r_enabled    <= n_enabled;
                r_homing     <= n_homing;
                r_step_wait  <= n_step_wait;
                r_lock_wait  <= n_lock_wait;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire
